// ===== rtl/olgp_pkg.sv =====
// Package for the octree leaf grid projection block.
// Holds command, mode and register codes, cell constants and the shared structs.
// No dependencies.
package olgp_pkg;

    // Commands carried by a request.
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_PAINT = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Merge modes; any code with the upper bit set paints nothing.
    localparam logic [1:0] MODE_DEFAULT = 2'd0;
    localparam logic [1:0] MODE_MAXIMUM = 2'd1;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_KEY_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_KEY_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FINEST_DEPTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MERGE_MODE   = 3'd5;

    // Register reset values.
    localparam logic [8:0]  RST_GRID_WIDTH   = 9'd256;
    localparam logic [8:0]  RST_GRID_HEIGHT  = 9'd256;
    localparam logic [15:0] RST_ORIGIN_KEY   = 16'd0;
    localparam logic [4:0]  RST_FINEST_DEPTH = 5'd16;
    localparam logic [1:0]  RST_MERGE_MODE   = MODE_MAXIMUM;

    // Cell values.
    localparam logic signed [7:0] CELL_UNKNOWN = -8'sd1;
    localparam logic signed [7:0] CELL_FREE    = 8'sd0;
    localparam logic signed [7:0] CELL_FULL    = 8'sd100;
    localparam logic [6:0]        PCT_MAX      = 7'd100;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] key_x;
        logic [15:0] key_y;
        logic [4:0]  leaf_depth;
        logic [6:0]  occupancy_percent;
        logic        is_occupied;
        logic [7:0]  cell_x;
        logic [7:0]  cell_y;
    } req_t;

    typedef struct packed {
        logic signed [7:0] cell_value;
        logic              clipped;
    } rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

    typedef struct packed {
        logic [8:0]  grid_width;
        logic [8:0]  grid_height;
        logic [15:0] origin_key_x;
        logic [15:0] origin_key_y;
        logic [4:0]  finest_depth;
        logic [1:0]  merge_mode;
    } cfg_regs_t;

    // Clamped footprint range along one axis.
    typedef struct packed {
        logic [8:0] lo;
        logic [8:0] hi;
        logic       empty;
        logic       clip;
    } axis_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       occupied;
        logic [6:0] percent;
    } paint_op_t;

    typedef struct packed {
        logic rd_en;
        logic paint;
        logic clr;
    } grid_ctl_t;

endpackage

// ===== rtl/olgp_if.sv =====
// Handshake interfaces for the request, response and configuration channels.
// Depends on olgp_pkg for the payload types.
interface olgp_req_if import olgp_pkg::*; ();
    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface olgp_rsp_if import olgp_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface olgp_cfg_if import olgp_pkg::*; ();
    logic    valid;
    logic    ready;
    cfg_wr_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/olgp_cfg_regs.sv =====
// Configuration register file of the grid projection block.
// Depends on olgp_pkg and the olgp_cfg_if interface.
module olgp_cfg_regs import olgp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    olgp_cfg_if.sink    cfg,
    output cfg_regs_t   regs
);

    cfg_regs_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.grid_width   <= RST_GRID_WIDTH;
            regs_reg.grid_height  <= RST_GRID_HEIGHT;
            regs_reg.origin_key_x <= RST_ORIGIN_KEY;
            regs_reg.origin_key_y <= RST_ORIGIN_KEY;
            regs_reg.finest_depth <= RST_FINEST_DEPTH;
            regs_reg.merge_mode   <= RST_MERGE_MODE;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.payload.index)
                REG_GRID_WIDTH:   regs_reg.grid_width   <= cfg.payload.data[8:0];
                REG_GRID_HEIGHT:  regs_reg.grid_height  <= cfg.payload.data[8:0];
                REG_ORIGIN_KEY_X: regs_reg.origin_key_x <= cfg.payload.data;
                REG_ORIGIN_KEY_Y: regs_reg.origin_key_y <= cfg.payload.data;
                REG_FINEST_DEPTH: regs_reg.finest_depth <= cfg.payload.data[4:0];
                REG_MERGE_MODE:   regs_reg.merge_mode   <= cfg.payload.data[1:0];
                default:          ;
            endcase
        end
    end

endmodule

// ===== rtl/olgp_axis_unit.sv =====
// Footprint range unit: turns a leaf key, origin and footprint size into a
// clamped cell range along one axis. Shared by both axes. Depends on olgp_pkg.
module olgp_axis_unit import olgp_pkg::*;
(
    input  logic [15:0] key,
    input  logic [15:0] origin,
    input  logic [4:0]  shift,
    input  logic [8:0]  limit,
    output axis_t       result
);

    logic signed [16:0] start;
    logic [31:0]        span;
    logic signed [33:0] stop;
    logic [16:0]        lo;
    logic [32:0]        hi;
    logic               clip;

    assign start = $signed({1'b0, key}) - $signed({1'b0, origin});
    assign span  = 32'((33'd1 << shift) - 33'd1);
    assign stop  = 34'(start) + $signed({2'b00, span});

    // Both ends collapse onto zero when they fall below the map corner.
    assign lo   = start[16] ? 17'd0 : $unsigned(start);
    assign hi   = stop[33]  ? 33'd0 : $unsigned(stop[32:0]);
    assign clip = hi >= {24'd0, limit};

    always_comb
    begin
        result.clip  = clip;
        result.empty = lo >= {8'd0, limit};
        result.lo    = lo[8:0];
        result.hi    = clip ? limit - 9'd1 : hi[8:0];
    end

endmodule

// ===== rtl/olgp_grid_mem.sv =====
// Grid cell memory with its merge unit: clear writes, single reads, and a
// one-cell-per-cycle read-modify-write for painting. Depends on olgp_pkg.
module olgp_grid_mem import olgp_pkg::*;
#(
    parameter int AW = 16
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  grid_ctl_t         ctl,
    input  logic [AW-1:0]     addr,
    input  paint_op_t         op,
    output logic signed [7:0] rd_data
);

    localparam int DEPTH = 1 << AW;

    logic signed [7:0] mem [0:DEPTH-1];
    logic signed [7:0] rd_data_reg;
    logic              pend_valid_reg;
    logic [AW-1:0]     pend_addr_reg;
    logic [6:0]        pct;
    logic signed [7:0] merged;
    logic              we;
    logic [AW-1:0]     waddr;
    logic signed [7:0] wdata;

    assign rd_data = rd_data_reg;
    assign pct     = (op.percent > PCT_MAX) ? PCT_MAX : op.percent;

    // The cell read in the previous cycle comes back here and is merged.
    always_comb
    begin
        merged = rd_data_reg;
        unique case (op.mode)
            MODE_DEFAULT:
            begin
                if (op.occupied)
                    merged = CELL_FULL;
                else if (rd_data_reg == CELL_UNKNOWN)
                    merged = CELL_FREE;
            end
            MODE_MAXIMUM:
            begin
                if ($signed({1'b0, pct}) > rd_data_reg)
                    merged = $signed({1'b0, pct});
            end
            default: merged = rd_data_reg;
        endcase
    end

    assign we    = ctl.clr || pend_valid_reg;
    assign waddr = ctl.clr ? addr : pend_addr_reg;
    assign wdata = ctl.clr ? CELL_UNKNOWN : merged;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (ctl.rd_en || ctl.paint)
            rd_data_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_valid_reg <= 1'b0;
        else
            pend_valid_reg <= ctl.paint;
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= addr;
    end

endmodule

// ===== rtl/octree_leaf_grid_projection.sv =====
// Octree leaf to 2D occupancy grid projection, iterative grid sequencer.
// Paint: x and y footprint setup, then one cell per cycle through the memory
// read-modify-write port and a drain state; the walk is skipped when nothing is painted.
// Read: a single cell, flagged clipped outside the grid. Other codes go straight to the response. Clear: every cell.
// After reset a clearing pass over every cell runs with req.ready low;
// configuration writes are taken at all times. One request is in work at once.
module octree_leaf_grid_projection import olgp_pkg::*;
#(
    parameter int GRID_W   = 256,
    parameter int GRID_H   = 256,
    parameter int KEY_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    olgp_req_if.sink    req,
    olgp_rsp_if.source  rsp,
    olgp_cfg_if.sink    cfg
);

    localparam int XB = (GRID_W > 1) ? $clog2(GRID_W) : 1;
    localparam int YB = (GRID_H > 1) ? $clog2(GRID_H) : 1;
    localparam int AW = XB + YB;
    localparam logic [15:0] KEY_MASK =
        (KEY_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << KEY_BITS) - 32'd1);
    localparam logic [XB-1:0] CLR_X_LAST = XB'(GRID_W - 1);
    localparam logic [YB-1:0] CLR_Y_LAST = YB'(GRID_H - 1);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_SETUP_X = 4'd2;
    localparam logic [3:0] S_SETUP_Y = 4'd3;
    localparam logic [3:0] S_PAINT   = 4'd4;
    localparam logic [3:0] S_DRAIN   = 4'd5;
    localparam logic [3:0] S_READ    = 4'd6;
    localparam logic [3:0] S_RWAIT   = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    cfg_regs_t         regs;
    logic [3:0]        state_reg, state_next;
    logic [XB-1:0]     clr_x_reg, clr_x_next;
    logic [YB-1:0]     clr_y_reg, clr_y_next;
    logic              clr_rsp_reg, clr_rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;
    req_t              req_reg, req_next;
    axis_t             ax_x_reg, ax_x_next;
    axis_t             ax_y_reg, ax_y_next;
    logic [8:0]        cur_x_reg, cur_x_next;
    logic [8:0]        cur_y_reg, cur_y_next;
    logic signed [7:0] value_reg, value_next;
    logic              clip_reg, clip_next;
    rsp_t              rsp_reg, rsp_next;

    logic [8:0]        w_eff, h_eff;
    logic [4:0]        shift;
    logic [15:0]       ax_key, ax_origin;
    logic [8:0]        ax_limit;
    axis_t             ax_out;
    logic              read_in;
    grid_ctl_t         ctl;
    logic [AW-1:0]     addr;
    logic [31:0]       ax_wide, ay_wide;
    paint_op_t         op;
    logic signed [7:0] rd_data;

    olgp_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    assign w_eff = (32'(regs.grid_width) < GRID_W) ? regs.grid_width : 9'(GRID_W);
    assign h_eff = (32'(regs.grid_height) < GRID_H) ? regs.grid_height : 9'(GRID_H);
    assign shift = (req_reg.leaf_depth < regs.finest_depth)
                 ? regs.finest_depth - req_reg.leaf_depth : 5'd0;

    // The range unit serves the x axis in the first setup state and y in the next.
    always_comb
    begin
        if (state_reg == S_SETUP_X)
        begin
            ax_key    = req_reg.key_x & KEY_MASK;
            ax_origin = regs.origin_key_x & KEY_MASK;
            ax_limit  = w_eff;
        end
        else
        begin
            ax_key    = req_reg.key_y & KEY_MASK;
            ax_origin = regs.origin_key_y & KEY_MASK;
            ax_limit  = h_eff;
        end
    end

    olgp_axis_unit u_axis (
        .key    (ax_key),
        .origin (ax_origin),
        .shift  (shift),
        .limit  (ax_limit),
        .result (ax_out)
    );

    assign read_in = ({1'b0, req_reg.cell_x} < w_eff) && ({1'b0, req_reg.cell_y} < h_eff);

    always_comb
    begin
        ctl.clr   = (state_reg == S_CLEAR);
        ctl.paint = (state_reg == S_PAINT);
        ctl.rd_en = (state_reg == S_READ) && read_in;
        ax_wide   = 32'(cur_x_reg);
        ay_wide   = 32'(cur_y_reg);
        unique case (state_reg)
            S_CLEAR: addr = {clr_y_reg, clr_x_reg};
            S_READ:
            begin
                ax_wide = 32'(req_reg.cell_x);
                ay_wide = 32'(req_reg.cell_y);
                addr    = {ay_wide[YB-1:0], ax_wide[XB-1:0]};
            end
            default: addr = {ay_wide[YB-1:0], ax_wide[XB-1:0]};
        endcase
    end

    assign op.mode     = regs.merge_mode;
    assign op.occupied = req_reg.is_occupied;
    assign op.percent  = req_reg.occupancy_percent;

    olgp_grid_mem #(
        .AW (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .addr    (addr),
        .op      (op),
        .rd_data (rd_data)
    );

    assign req.ready   = (state_reg == S_IDLE);
    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_x_next     = clr_x_reg;
        clr_y_next     = clr_y_reg;
        clr_rsp_next   = clr_rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        req_next       = req_reg;
        ax_x_next      = ax_x_reg;
        ax_y_next      = ax_y_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        value_next     = value_reg;
        clip_next      = clip_reg;
        rsp_next       = rsp_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_x_reg == CLR_X_LAST)
                begin
                    clr_x_next = '0;
                    if (clr_y_reg == CLR_Y_LAST)
                    begin
                        clr_y_next   = '0;
                        clr_rsp_next = 1'b0;
                        state_next   = clr_rsp_reg ? S_DONE : S_IDLE;
                    end
                    else
                        clr_y_next = clr_y_reg + YB'(1);
                end
                else
                    clr_x_next = clr_x_reg + XB'(1);
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    req_next   = req.payload;
                    value_next = '0;
                    clip_next  = 1'b0;
                    unique case (req.payload.command)
                        CMD_CLEAR:
                        begin
                            clr_rsp_next = 1'b1;
                            state_next   = S_CLEAR;
                        end
                        CMD_PAINT: state_next = S_SETUP_X;
                        CMD_READ:  state_next = S_READ;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_SETUP_X:
            begin
                ax_x_next  = ax_out;
                state_next = S_SETUP_Y;
            end
            S_SETUP_Y:
            begin
                ax_y_next  = ax_out;
                clip_next  = ax_x_reg.clip || ax_out.clip;
                cur_x_next = ax_x_reg.lo;
                cur_y_next = ax_out.lo;
                if (regs.merge_mode[1] || ax_x_reg.empty || ax_out.empty)
                    state_next = S_DONE;
                else
                    state_next = S_PAINT;
            end
            S_PAINT:
            begin
                if (cur_x_reg == ax_x_reg.hi)
                begin
                    cur_x_next = ax_x_reg.lo;
                    if (cur_y_reg == ax_y_reg.hi)
                        state_next = S_DRAIN;
                    else
                        cur_y_next = cur_y_reg + 9'd1;
                end
                else
                    cur_x_next = cur_x_reg + 9'd1;
            end
            S_DRAIN: state_next = S_DONE;
            S_READ:
            begin
                if (read_in)
                    state_next = S_RWAIT;
                else
                begin
                    clip_next  = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_RWAIT:
            begin
                value_next = rd_data;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_next.cell_value = value_reg;
                    rsp_next.clipped    = clip_reg;
                    rsp_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_x_reg     <= '0;
            clr_y_reg     <= '0;
            clr_rsp_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_x_reg     <= clr_x_next;
            clr_y_reg     <= clr_y_next;
            clr_rsp_reg   <= clr_rsp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        ax_x_reg  <= ax_x_next;
        ax_y_reg  <= ax_y_next;
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        value_reg <= value_next;
        clip_reg  <= clip_next;
        rsp_reg   <= rsp_next;
    end

`ifndef SYNTHESIS
    // The paint walk never leaves the grid.
    a_paint_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAINT) |-> (cur_x_reg < w_eff) && (cur_y_reg < h_eff))
        else $error("paint position outside the grid");

    // The paint walk stays inside the footprint range.
    a_paint_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAINT) |-> (cur_x_reg >= ax_x_reg.lo) && (cur_x_reg <= ax_x_reg.hi)
                                && (cur_y_reg >= ax_y_reg.lo) && (cur_y_reg <= ax_y_reg.hi))
        else $error("paint position outside the footprint");

    // A response is only launched from the completion state.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !$past(rsp_valid_reg && !rsp.ready)) |-> $past(state_reg == S_DONE))
        else $error("response launched outside completion");
`endif

endmodule
